// ===== hdl/mdvr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdvr_pkg
// Shared constants, widths and the CORDIC arctangent table for the rotator.
// ----------------------------------------------------------------------------
package mdvr_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int MOUSE_BITS   = 16;
    localparam int POS_BITS     = (MOUSE_BITS < 16) ? MOUSE_BITS : 16;

    localparam int TURN_W  = 24;
    localparam int VEC_W   = 16;
    localparam int CORD_W  = 28;   // Q6.22 working width with growth margin
    localparam int ANG_W   = 34;   // angle in 2^-32 turn units, signed
    localparam int GAIN_W  = 30;
    localparam int ACC_W   = 60;
    localparam int CNT_W   = 5;

    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
    localparam logic [TURN_W-1:0] TPP_RESET = 24'd13;
    localparam logic signed [VEC_W-1:0] ONE_Q14   = 16'sd16384;
    localparam logic signed [VEC_W-1:0] SMALL_Q14 = 16'sd164;

    typedef enum logic [1:0] {
        HEAD_NORTH = 2'd0,
        HEAD_EAST  = 2'd1,
        HEAD_SOUTH = 2'd2,
        HEAD_WEST  = 2'd3
    } heading_t;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    function automatic logic [31:0] atan_turn(input logic [CNT_W-1:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/mdvr_gain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdvr_gain
// Bit-serial CORDIC gain correction: one multiplier bit per cycle, then
// rounding to Q2.14 and saturation to 16 bits.
// ----------------------------------------------------------------------------
module mdvr_gain (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  start,
    input  wire signed [mdvr_pkg::CORD_W-1:0]    value,
    output logic                                 done,
    output logic signed [mdvr_pkg::VEC_W-1:0]    result
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [mdvr_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [mdvr_pkg::ACC_W-1:0]   shf_reg, shf_next;
    logic signed [mdvr_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic signed [mdvr_pkg::ACC_W-1:0]   rnd;
    logic signed [mdvr_pkg::ACC_W-39:0]  shr;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        shf_next  = shf_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            shf_next  = mdvr_pkg::ACC_W'(value);
            acc_next  = '0;
        end else if (busy_reg) begin
            if (mdvr_pkg::GAIN_Q30[cnt_reg]) begin
                acc_next = acc_reg + shf_reg;
            end
            shf_next = shf_reg <<< 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mdvr_pkg::CNT_W'(mdvr_pkg::GAIN_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        shf_reg <= shf_next;
        acc_reg <= acc_next;
    end

    // Round half up at bit 38, then clamp to the 16-bit range.
    always_comb begin
        rnd = acc_reg + (mdvr_pkg::ACC_W'(1) <<< 37);
        shr = rnd[mdvr_pkg::ACC_W-1:38];
        if (shr > 22'sd32767) begin
            result = 16'sd32767;
        end else if (shr < -22'sd32768) begin
            result = -16'sd32768;
        end else begin
            result = shr[15:0];
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire

// ===== hdl/mouse_driven_vector_rotator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mouse_driven_vector_rotator_core
// Heading vector rotator driven by horizontal mouse motion.
// ----------------------------------------------------------------------------
// Input channel s_*: one request per item. opcode 0 loads a unit vector for
// a compass heading, opcode 1 is a mouse x sample that rotates the vector by
// (x - previous x) * turn_per_pixel. Every request gives one result on m_*,
// the new vector and a flag that says whether a rotation was applied.
// turn_per_pixel is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, since the core does not enforce this. A load goes
// straight to the output register. A sample runs a bit-serial angle multiply,
// a quadrant step, 16 CORDIC iterations (one per cycle), the bit-serial gain
// multiply with its start and done handoff, then the zero fix and output; a
// sample with zero angle skips CORDIC and gain. One request is processed at
// a time; the serial multipliers set the rate. s_tready returns in the same
// cycle that the result is registered on m_*; a new request is taken only
// once the previous one is through, not while it is still in flight.
// A new request is taken while the previous result still waits on m_*.
// If the receiver stalls, the finished result waits in the core until the
// output register frees up. Reset clears the vector, the last mouse position
// and the first-sample flag, restores turn_per_pixel to 13 and drops m_tvalid.
// ----------------------------------------------------------------------------
module mouse_driven_vector_rotator_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [23:0] cfg_wr_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // [0] opcode, [2:1] heading, [18:3] mouse_x
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata    // [15:0] dir_x_out, [31:16] dir_y_out, [32] rotated
);

    localparam int CW = mdvr_pkg::CORD_W;
    localparam int AW = mdvr_pkg::ANG_W;
    localparam int VW = mdvr_pkg::VEC_W;
    localparam int TW = mdvr_pkg::TURN_W;
    localparam int NW = mdvr_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_PREP, ST_CORD, ST_GAIN, ST_FIX, ST_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [TW-1:0]           tpp_reg;
    logic signed [VW-1:0]    vx_reg, vx_next, vy_reg, vy_next;
    logic signed [VW-1:0]    last_reg, last_next;
    logic                    seen_reg, seen_next;
    logic                    rot_reg, rot_next;
    logic [NW-1:0]           cnt_reg, cnt_next;
    logic [TW-1:0]           mcand_reg, mcand_next, mplier_reg, mplier_next;
    logic [TW-1:0]           ang_reg, ang_next;
    logic signed [CW-1:0]    cx_reg, cx_next, cy_reg, cy_next;
    logic signed [AW-1:0]    cz_reg, cz_next;
    logic                    gstart_reg, gstart_next;
    logic                    mv_reg, mv_next;
    logic [39:0]             md_reg, md_next;

    logic                    in_op;
    logic [1:0]              in_head;
    logic signed [VW-1:0]    in_pos;
    logic signed [VW:0]      delta;
    logic [TW-1:0]           qsum, zrem;
    logic [1:0]              quad;
    logic signed [VW:0]      qx, qy;
    logic signed [CW-1:0]    dx, dy;
    logic signed [AW-1:0]    atan_v;
    logic                    gx_done, gy_done;
    logic signed [VW-1:0]    gx_res, gy_res;

    assign in_op   = s_tdata[0];
    assign in_head = s_tdata[2:1];
    assign in_pos  = $signed(s_tdata[18:3] <<< (VW - mdvr_pkg::POS_BITS))
                     >>> (VW - mdvr_pkg::POS_BITS);
    assign delta   = (VW + 1)'(in_pos) - (seen_reg ? (VW + 1)'(last_reg) : (VW + 1)'(in_pos));

    assign qsum   = ang_reg + (TW'(1) << 21);
    assign quad   = qsum[23:22];
    assign zrem   = ang_reg - {quad, 22'd0};
    assign dx     = cy_reg >>> cnt_reg;
    assign dy     = cx_reg >>> cnt_reg;
    assign atan_v = AW'(mdvr_pkg::atan_turn(cnt_reg));

    always_comb begin
        qx = (VW + 1)'(vx_reg);
        qy = (VW + 1)'(vy_reg);
        case (quad)
            2'd1: begin qx = -(VW + 1)'(vy_reg); qy = (VW + 1)'(vx_reg); end
            2'd2: begin qx = -(VW + 1)'(vx_reg); qy = -(VW + 1)'(vy_reg); end
            2'd3: begin qx = (VW + 1)'(vy_reg); qy = -(VW + 1)'(vx_reg); end
            default: begin qx = (VW + 1)'(vx_reg); qy = (VW + 1)'(vy_reg); end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        last_next   = last_reg;
        seen_next   = seen_reg;
        rot_next    = rot_reg;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        ang_next    = ang_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        cz_next     = cz_reg;
        gstart_next = 1'b0;
        mv_next     = mv_reg;
        md_next     = md_reg;
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    rot_next = 1'b0;
                    if (in_op == mdvr_pkg::OP_LOAD) begin
                        vx_next = '0;
                        vy_next = '0;
                        case (mdvr_pkg::heading_t'(in_head))
                            mdvr_pkg::HEAD_NORTH: vy_next = -mdvr_pkg::ONE_Q14;
                            mdvr_pkg::HEAD_EAST:  vx_next = mdvr_pkg::ONE_Q14;
                            mdvr_pkg::HEAD_SOUTH: vy_next = mdvr_pkg::ONE_Q14;
                            mdvr_pkg::HEAD_WEST:  vx_next = -mdvr_pkg::ONE_Q14;
                            default: vx_next = '0;
                        endcase
                        state_next = ST_OUT;
                    end else begin
                        seen_next   = 1'b1;
                        last_next   = in_pos;
                        mcand_next  = tpp_reg;
                        mplier_next = TW'(delta);
                        ang_next    = '0;
                        cnt_next    = '0;
                        state_next  = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                // Shift-add multiply; the product wraps at one full turn.
                if (mplier_reg[0]) begin
                    ang_next = ang_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == NW'(TW - 1)) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (ang_reg == '0) begin
                    state_next = ST_FIX;
                end else begin
                    cx_next    = {{(CW - VW - 9){qx[VW]}}, qx, 8'd0};
                    cy_next    = {{(CW - VW - 9){qy[VW]}}, qy, 8'd0};
                    cz_next    = {{(AW - TW - 8){zrem[TW-1]}}, zrem, 8'd0};
                    cnt_next   = '0;
                    state_next = ST_CORD;
                end
            end
            ST_CORD: begin
                if (!cz_reg[AW-1]) begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - atan_v;
                end else begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + atan_v;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == NW'(mdvr_pkg::CORDIC_STEPS - 1)) begin
                    gstart_next = 1'b1;
                    state_next  = ST_GAIN;
                end
            end
            ST_GAIN: begin
                if (gx_done && gy_done) begin
                    vx_next    = gx_res;
                    vy_next    = gy_res;
                    rot_next   = 1'b1;
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                if (vx_reg == '0) begin
                    vx_next = mdvr_pkg::SMALL_Q14;
                end
                if (vy_reg == '0) begin
                    vy_next = mdvr_pkg::SMALL_Q14;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {7'd0, rot_reg, vy_reg, vx_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tpp_reg    <= mdvr_pkg::TPP_RESET;
            vx_reg     <= '0;
            vy_reg     <= '0;
            last_reg   <= '0;
            seen_reg   <= 1'b0;
            rot_reg    <= 1'b0;
            gstart_reg <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            if (cfg_wr_en) begin
                tpp_reg <= cfg_wr_data;
            end
            vx_reg     <= vx_next;
            vy_reg     <= vy_next;
            last_reg   <= last_next;
            seen_reg   <= seen_next;
            rot_reg    <= rot_next;
            gstart_reg <= gstart_next;
            mv_reg     <= mv_next;
        end
        cnt_reg    <= cnt_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        ang_reg    <= ang_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        md_reg     <= md_next;
    end

    mdvr_gain u_gain_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gstart_reg),
        .value   (cx_reg),
        .done    (gx_done),
        .result  (gx_res)
    );

    mdvr_gain u_gain_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gstart_reg),
        .value   (cy_reg),
        .done    (gy_done),
        .result  (gy_res)
    );

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

endmodule
`default_nettype wire

// ===== hdl/mdvr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdvr_checker
// Port-level checks for the rotator core, attached by bind.
// ----------------------------------------------------------------------------
module mdvr_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata
);

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A rotated vector never carries a zero component.
    a_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> (m_tdata[15:0] != 16'd0) && (m_tdata[31:16] != 16'd0))
        else $error("zero component after rotation");

    // Padding bits stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:33] == 7'd0)
        else $error("nonzero padding in result");

    // A request is never taken in the cycle right after another one.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

endmodule

bind mouse_driven_vector_rotator_core mdvr_checker u_mdvr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the mouse-driven heading rotator. A short directed table runs
// first, then random loads and mouse samples under several rotation rates.
// Every result is checked against its typed table entry or a cycle-free model.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 120;
    localparam logic [23:0] TURN_MASK = 24'hFFFFFF;

    typedef struct packed {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic               rot;
    } heading_res_t;

    typedef struct {
        logic                  op;
        mdvr_pkg::heading_t    hd;
        int                    mx;
        bit                    typed;
        int                    ex;
        int                    ey;
        bit                    er;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [23:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [23:0] s_tdata = '0;   // [0] opcode, [2:1] heading, [18:3] mouse_x
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [39:0] m_tdata;        // [15:0] dir_x_out, [31:16] dir_y_out, [32] rotated

    mouse_driven_vector_rotator_core DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Model state.
    logic [23:0]  rate_q;
    int           hx, hy, prev_pos;
    bit           have_pos;
    heading_res_t pending_dirs[$];
    int           errors = 0;
    int           cycles = 0;
    bit           quiet = 1'b0;
    int           rx_stall = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic int gain_round(input longint v);
        longint p;
        p = floor_shift(v * 64'sd652032874 + (64'sd1 <<< 37), 38);
        if (p > 32767) return 32767;
        if (p < -32768) return -32768;
        return int'(p);
    endfunction

    function automatic void rotate_heading(input logic [23:0] angle);
        logic [31:0] q;
        logic [23:0] rem;
        longint x, y, z, t, ddx, ddy, at;
        q = ((32'(angle) + (32'd1 << 21)) >> 22) & 32'd3;
        rem = 24'(32'(angle) - (q << 22));
        z = longint'($signed(rem)) * 256;
        x = hx;
        y = hy;
        if (q == 1) begin
            t = x; x = -y; y = t;
        end else if (q == 2) begin
            x = -x; y = -y;
        end else if (q == 3) begin
            t = x; x = y; y = -t;
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < mdvr_pkg::CORDIC_STEPS; i++) begin
            ddx = floor_shift(y, i);
            ddy = floor_shift(x, i);
            at = longint'(mdvr_pkg::atan_turn(mdvr_pkg::CNT_W'(i)));
            if (z >= 0) begin
                x -= ddx; y += ddy; z -= at;
            end else begin
                x += ddx; y -= ddy; z += at;
            end
        end
        hx = gain_round(x);
        hy = gain_round(y);
    endfunction

    function automatic heading_res_t next_heading(input logic op,
                                                  input mdvr_pkg::heading_t hd,
                                                  input logic [15:0] mx);
        heading_res_t r;
        int pos;
        longint delta;
        logic [23:0] angle;
        r.rot = 1'b0;
        if (op == mdvr_pkg::OP_LOAD) begin
            hx = (hd == mdvr_pkg::HEAD_EAST) ? 16384 : (hd == mdvr_pkg::HEAD_WEST) ? -16384 : 0;
            hy = (hd == mdvr_pkg::HEAD_SOUTH) ? 16384 : (hd == mdvr_pkg::HEAD_NORTH) ? -16384 : 0;
        end else begin
            pos = int'($signed(mx << (16 - mdvr_pkg::POS_BITS))) >>> (16 - mdvr_pkg::POS_BITS);
            if (!have_pos) begin
                prev_pos = pos;
                have_pos = 1'b1;
            end
            delta = longint'(pos) - longint'(prev_pos);
            angle = 24'(delta * longint'(rate_q)) & TURN_MASK;
            if (angle != 0) begin
                rotate_heading(angle);
                r.rot = 1'b1;
            end
            if (hx == 0) hx = 164;
            if (hy == 0) hy = 164;
            prev_pos = pos;
        end
        r.dx = 16'(hx);
        r.dy = 16'(hy);
        return r;
    endfunction

    // One request on the input channel; the model runs when it is accepted.
    task automatic send_item(input logic op, input mdvr_pkg::heading_t hd,
                             input logic [15:0] mx,
                             input bit typed, input heading_res_t want);
        heading_res_t r;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, mx, hd, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = next_heading(op, hd, mx);
        pending_dirs.push_back(typed ? want : r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_dirs.size() != 0) @(posedge aclk);
    endtask

    task automatic set_rate(input logic [23:0] v);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        rate_q = v;
    endtask

    task automatic random_phase(input int n);
        int r;
        logic [15:0] mx;
        heading_res_t none;
        none = '0;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_item(mdvr_pkg::OP_LOAD, mdvr_pkg::heading_t'($urandom_range(0, 3)),
                          16'($urandom), 1'b0, none);
            end else begin
                if (r < 25) mx = 16'($urandom);
                else if (r < 30) mx = 16'(prev_pos);
                else mx = 16'(prev_pos + $urandom_range(0, 80) - 40);
                send_item(mdvr_pkg::OP_SAMPLE, mdvr_pkg::heading_t'($urandom_range(0, 3)),
                          mx, 1'b0, none);
            end
        end
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rx_stall <= $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        heading_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_dirs.size() == 0) begin
                report("unexpected result", m_tdata[32:0], 0);
            end else begin
                want = pending_dirs.pop_front();
                if (m_tdata[15:0] !== want.dx)
                    report("dir_x_out", $signed(m_tdata[15:0]), want.dx);
                if (m_tdata[31:16] !== want.dy)
                    report("dir_y_out", $signed(m_tdata[31:16]), want.dy);
                if (m_tdata[32] !== want.rot)
                    report("rotated", m_tdata[32], want.rot);
            end
        end
    end

    dir_row_t dir_rows [] = '{
        '{mdvr_pkg::OP_LOAD,   mdvr_pkg::HEAD_NORTH, 0,      1, 0,      -16384, 0},
        '{mdvr_pkg::OP_LOAD,   mdvr_pkg::HEAD_EAST,  -1,     1, 16384,  0,      0},
        // The first sample only records the position; y is lifted off zero.
        '{mdvr_pkg::OP_SAMPLE, mdvr_pkg::HEAD_WEST,  -32768, 1, 16384,  164,    0},
        '{mdvr_pkg::OP_SAMPLE, mdvr_pkg::HEAD_NORTH, 32767,  0, 0,      0,      0},
        '{mdvr_pkg::OP_SAMPLE, mdvr_pkg::HEAD_EAST,  32767,  0, 0,      0,      0},
        '{mdvr_pkg::OP_SAMPLE, mdvr_pkg::HEAD_SOUTH, -32768, 0, 0,      0,      0},
        '{mdvr_pkg::OP_LOAD,   mdvr_pkg::HEAD_SOUTH, 32767,  1, 0,      16384,  0},
        '{mdvr_pkg::OP_SAMPLE, mdvr_pkg::HEAD_SOUTH, -32767, 0, 0,      0,      0},
        '{mdvr_pkg::OP_LOAD,   mdvr_pkg::HEAD_WEST,  0,      1, -16384, 0,      0},
        '{mdvr_pkg::OP_SAMPLE, mdvr_pkg::HEAD_NORTH, -32766, 0, 0,      0,      0},
        '{mdvr_pkg::OP_SAMPLE, mdvr_pkg::HEAD_WEST,  0,      0, 0,      0,      0},
        '{mdvr_pkg::OP_SAMPLE, mdvr_pkg::HEAD_EAST,  21845,  0, 0,      0,      0},
        '{mdvr_pkg::OP_SAMPLE, mdvr_pkg::HEAD_EAST,  -21846, 0, 0,      0,      0}
    };

    initial begin
        heading_res_t want;
        rate_q = mdvr_pkg::TPP_RESET;
        hx = 0; hy = 0; prev_pos = 0; have_pos = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            want.dx = 16'(dir_rows[i].ex);
            want.dy = 16'(dir_rows[i].ey);
            want.rot = dir_rows[i].er;
            send_item(dir_rows[i].op, dir_rows[i].hd, 16'(dir_rows[i].mx),
                      dir_rows[i].typed, want);
        end

        // With a zero rate every move gives a zero angle.
        set_rate(24'd0);
        want = '0;
        send_item(mdvr_pkg::OP_LOAD, mdvr_pkg::HEAD_NORTH, 16'd0, 1'b0, want);
        send_item(mdvr_pkg::OP_SAMPLE, mdvr_pkg::HEAD_NORTH, 16'd1234, 1'b0, want);
        random_phase(60);
        set_rate(TURN_MASK);
        random_phase(150);
        set_rate(24'd1);
        random_phase(100);
        set_rate(24'h400000);
        random_phase(60);
        set_rate(24'(mdvr_pkg::TPP_RESET));
        random_phase(120);
        wait_drained();
        set_rate(24'($urandom));
        random_phase(150);
        set_rate(24'($urandom_range(1, 4096)));
        random_phase(150);
        quiet = 1'b1;
        random_phase(100);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
